// File: rtl/core/rmv_pkg.sv
// Package for the running mean and variance block.
// Holds shared widths, the controller state type and the command/status structs.
// No dependencies.
package rmv_pkg;

  // Default widths for the top-level parameters
  localparam int SampleWidthDef = 32;
  localparam int CountWidthDef  = 32;

  // Fixed widths of the squared-deviation sum and the variance result
  localparam int SumWidth  = 64;
  localparam int VarWidth  = 63;
  localparam int IterWidth = $clog2(SumWidth + 1);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_MEAN,
    ST_DEV,
    ST_MUL,
    ST_VAR_START,
    ST_DIV_VAR,
    ST_OUT
  } rmv_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic first_load;
    logic div_mean_start;
    logic mean_update;
    logic mul_start;
    logic sum_update;
    logic div_var_start;
    logic var_update;
    logic out_load;
  } rmv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic first;
    logic div_done;
    logic mul_done;
    logic out_free;
  } rmv_sts_t;

endpackage

// File: rtl/core/rmv_if.sv
// Stream interfaces for the sample input and the result output.
// Valid/ready handshake; depends on rmv_pkg for the default widths and the variance width.
interface rmv_smp_if #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SampleWidthDef
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmv_res_if #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = rmv_pkg::CountWidthDef
) ();
  import rmv_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic [VarWidth-1:0]            variance;
  logic                           variance_valid;
  logic [COUNT_WIDTH-1:0]         sample_count;

  modport source (output valid, output mean, output variance, output variance_valid,
                  output sample_count, input ready);
  modport sink   (input valid, input mean, input variance, input variance_valid,
                  input sample_count, output ready);
endinterface

// File: rtl/core/rmv_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Shared for the mean step and the variance; depends on rmv_pkg.
module rmv_div #(
  parameter int NUM_W = rmv_pkg::SumWidth,
  parameter int DEN_W = rmv_pkg::CountWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [DEN_W-1:0]           den_i,
  input  logic [rmv_pkg::IterWidth-1:0] iters_i,
  output logic [NUM_W-1:0]           quot_o,
  output logic                       done_o
);
  import rmv_pkg::*;

  logic [NUM_W-1:0]     quot_q, quot_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q;
  logic [IterWidth-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quot_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d  = diff[DEN_W-1:0];
      quot_d = {quot_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d  = trial[DEN_W-1:0];
      quot_d = {quot_q[NUM_W-2:0], 1'b0};
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - IterWidth'(1);
      if (cnt_q == IterWidth'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/rmv_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, unsigned operands.
// Forms the product of the two deviation magnitudes; no package dependency.
module rmv_mul #(
  parameter int W = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] prod_o,
  output logic           done_o
);
  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    a_q;
  logic [2*W-1:0]  prod_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [W:0]      psum;

  // Add the multiplicand into the upper half when the low bit is set
  assign psum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Product register shifts right one bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {psum, prod_q[W-1:1]};
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/rmv_dp.sv
// Datapath: sample count, running mean, squared-deviation sum and result register.
// Uses rmv_div and rmv_mul; takes commands and types from rmv_pkg.
module rmv_dp #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = rmv_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rmv_pkg::rmv_cmd_t              cmd_i,
  output rmv_pkg::rmv_sts_t              sts_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] mean_o,
  output logic [rmv_pkg::VarWidth-1:0]   variance_o,
  output logic                           variance_valid_o,
  output logic [COUNT_WIDTH-1:0]         sample_count_o
);
  import rmv_pkg::*;

  localparam int DiffW = SAMPLE_WIDTH + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int ExtW  = (ProdW > SumWidth) ? ProdW : SumWidth + 1;
  localparam int PadW  = SumWidth - DiffW;

  // Running state
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic [COUNT_WIDTH-1:0]         count_q;
  logic signed [SAMPLE_WIDTH-1:0] mean_q;
  logic [SumWidth-1:0]            sum_q;
  logic                           first_q;
  logic                           d_neg_q;
  logic [DiffW-1:0]               d_mag_q;
  logic [VarWidth-1:0]            var_q;
  logic                           vvalid_q;

  // Result register
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_mean_q;
  logic [VarWidth-1:0]            out_var_q;
  logic                           out_vvalid_q;
  logic [COUNT_WIDTH-1:0]         out_count_q;

  // Combinational terms
  logic [DiffW-1:0]       d;
  logic [DiffW-1:0]       d_mag;
  logic [DiffW-1:0]       q_mag;
  logic [DiffW-1:0]       q_signed;
  logic [DiffW-1:0]       mean_new;
  logic [DiffW-1:0]       e;
  logic [DiffW-1:0]       e_mag;
  logic [ProdW-1:0]       prod;
  logic [ExtW-1:0]        prod_ext;
  logic [SumWidth-1:0]    prod_sat;
  logic [SumWidth:0]      sum_add;
  logic [SumWidth-1:0]    sum_new;
  logic [SumWidth-1:0]    quot;
  logic                   div_start;
  logic [SumWidth-1:0]    div_num;
  logic [COUNT_WIDTH-1:0] div_den;
  logic [IterWidth-1:0]   div_iters;
  logic                   div_done;
  logic                   mul_done;

  // Deviation of the sample from the old mean
  assign d     = {x_q[SAMPLE_WIDTH-1], x_q} - {mean_q[SAMPLE_WIDTH-1], mean_q};
  assign d_mag = d[DiffW-1] ? (DiffW'(0) - d) : d;

  // Mean step: apply the sign of the deviation to the truncated quotient
  assign q_mag    = quot[DiffW-1:0];
  assign q_signed = d_neg_q ? (DiffW'(0) - q_mag) : q_mag;
  assign mean_new = {mean_q[SAMPLE_WIDTH-1], mean_q} + q_signed;

  // Deviation of the sample from the new mean
  assign e     = {x_q[SAMPLE_WIDTH-1], x_q} - {mean_q[SAMPLE_WIDTH-1], mean_q};
  assign e_mag = e[DiffW-1] ? (DiffW'(0) - e) : e;

  // Saturate the product to the sum width, then add with saturation
  assign prod_ext = ExtW'(prod);
  assign prod_sat = (|prod_ext[ExtW-1:SumWidth]) ? {SumWidth{1'b1}} : prod_ext[SumWidth-1:0];
  assign sum_add  = {1'b0, sum_q} + {1'b0, prod_sat};
  assign sum_new  = sum_add[SumWidth] ? {SumWidth{1'b1}} : sum_add[SumWidth-1:0];

  // Divider operand select: deviation by count, or sum by count minus one
  assign div_start = cmd_i.div_mean_start | cmd_i.div_var_start;
  always_comb begin
    if (cmd_i.div_mean_start) begin
      div_num   = {d_mag, {PadW{1'b0}}};
      div_den   = count_q;
      div_iters = IterWidth'(DiffW);
    end else begin
      div_num   = sum_q;
      div_den   = count_q - COUNT_WIDTH'(1);
      div_iters = IterWidth'(SumWidth);
    end
  end

  rmv_div #(
    .NUM_W (SumWidth),
    .DEN_W (COUNT_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  rmv_mul #(
    .W (DiffW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (d_mag_q),
    .b_i     (e_mag),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  // Running state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mean_q  <= '0;
      sum_q   <= '0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (count_q != {COUNT_WIDTH{1'b1}}) begin
          count_q <= count_q + COUNT_WIDTH'(1);
        end
        first_q <= (count_q == '0);
      end
      if (cmd_i.first_load) begin
        mean_q <= x_q;
        sum_q  <= '0;
      end
      if (cmd_i.mean_update) begin
        mean_q <= mean_new[SAMPLE_WIDTH-1:0];
      end
      if (cmd_i.sum_update) begin
        sum_q <= sum_new;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
    if (cmd_i.div_mean_start) begin
      d_neg_q <= d[DiffW-1];
      d_mag_q <= d_mag;
    end
    if (cmd_i.first_load) begin
      var_q    <= '0;
      vvalid_q <= 1'b0;
    end
    if (cmd_i.var_update) begin
      var_q    <= quot[SumWidth-1] ? {VarWidth{1'b1}} : quot[VarWidth-1:0];
      vvalid_q <= 1'b1;
    end
  end

  // Result register: load wins over drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mean_q   <= mean_q;
      out_var_q    <= var_q;
      out_vvalid_q <= vvalid_q;
      out_count_q  <= count_q;
    end
  end

  assign sts_o.first    = first_q;
  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = ~out_valid_q | res_ready_i;

  assign res_valid_o      = out_valid_q;
  assign mean_o           = out_mean_q;
  assign variance_o       = out_var_q;
  assign variance_valid_o = out_vvalid_q;
  assign sample_count_o   = out_count_q;

endmodule

// File: rtl/core/rmv_ctrl.sv
// Controller state machine: sequences accept, mean division, product,
// sum update, variance division and result load. Depends on rmv_pkg.
module rmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              smp_valid_i,
  output logic              smp_ready_o,
  input  rmv_pkg::rmv_sts_t sts_i,
  output rmv_pkg::rmv_cmd_t cmd_o
);
  import rmv_pkg::*;

  rmv_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    smp_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        smp_ready_o = 1'b1;
        if (smp_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.first) begin
          cmd_o.first_load = 1'b1;
          state_d          = ST_OUT;
        end else begin
          cmd_o.div_mean_start = 1'b1;
          state_d              = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (sts_i.div_done) begin
          cmd_o.mean_update = 1'b1;
          state_d           = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.sum_update = 1'b1;
          state_d          = ST_VAR_START;
        end
      end
      ST_VAR_START: begin
        cmd_o.div_var_start = 1'b1;
        state_d             = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        if (sts_i.div_done) begin
          cmd_o.var_update = 1'b1;
          state_d          = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/running_mean_variance.sv
// Running mean and sample variance (Welford form) over signed fixed-point samples.
// Later samples pass the bit-serial divider (SAMPLE_WIDTH + 1 and 64 steps) and the
// bit-serial multiplier (SAMPLE_WIDTH + 1 steps); the first sample goes straight to the
// result register. One sample in flight at a time; the next is taken the cycle after the
// result is loaded, even while it waits on the output.
// Reset (asynchronous, active low) clears count, mean and sum and empties the output.
module running_mean_variance #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = rmv_pkg::CountWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmv_smp_if.sink   smp_i,
  rmv_res_if.source res_o
);
  import rmv_pkg::*;

  rmv_cmd_t cmd;
  rmv_sts_t sts;

  rmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_i.valid),
    .smp_ready_o (smp_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmv_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (smp_i.sample),
    .res_valid_o      (res_o.valid),
    .res_ready_i      (res_o.ready),
    .mean_o           (res_o.mean),
    .variance_o       (res_o.variance),
    .variance_valid_o (res_o.variance_valid),
    .sample_count_o   (res_o.sample_count)
  );

endmodule

// File: tb/testbench.sv
// Self-checking bench for running_mean_variance: drives samples over rmv_smp_if,
// predicts Welford mean/variance/count per sample and checks every result beat.
// Depends on rmv_pkg, rmv_smp_if, rmv_res_if and the running_mean_variance RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmv_pkg::*;

  localparam int     SmpW       = SampleWidthDef;
  localparam int     CntW       = CountWidthDef;
  localparam longint MaxSample  = 64'sd2147483647;
  localparam longint MinSample  = -64'sd2147483648;
  localparam longint CountMax   = 64'sd4294967295;
  localparam int     IdleLimit  = 20000;
  localparam int     DrainWait  = 200;
  localparam int     RandItems  = 1500;
  localparam int     HoldAfter  = 400;
  localparam int     HoldCycles = 3000;

  typedef struct packed {
    logic signed [SmpW-1:0] mean;
    logic [VarWidth-1:0]    variance;
    logic                   var_ok;
    logic [CntW-1:0]        count;
  } stats_t;

  // Welford predictor plus the queue of stats still owed by the block
  class mean_var_tracker;
    longint         n_seen;
    longint         mean_now;
    logic [63:0]    dev_sum;
    stats_t         stats_due[$];
    int             fails;

    function new();
      n_seen   = 0;
      mean_now = 0;
      dev_sum  = '0;
      fails    = 0;
    endfunction

    // Advance the running stats by one accepted sample and queue the result
    function void note_sample(logic signed [SmpW-1:0] x);
      longint       xs, d, q, e;
      logic [63:0]  ad, ae, divisor, quo;
      logic [127:0] prod;
      logic [64:0]  acc;
      stats_t       r;
      xs = longint'(x);
      r.variance = '0;
      r.var_ok   = 1'b0;
      if (n_seen < CountMax) n_seen++;
      if (n_seen <= 1) begin
        mean_now = xs;
        dev_sum  = '0;
      end else begin
        d = xs - mean_now;
        q = d / n_seen;
        mean_now = mean_now + q;
        e = xs - mean_now;
        ad = (d < 0) ? -d : d;
        ae = (e < 0) ? -e : e;
        prod = {64'b0, ad} * {64'b0, ae};
        // saturate the product, then the sum; a saturated sum stays put
        if (prod[127:64] != '0) prod[63:0] = '1;
        acc = {1'b0, dev_sum} + {1'b0, prod[63:0]};
        dev_sum = acc[64] ? '1 : acc[63:0];
        divisor = n_seen - 1;
        quo = dev_sum / divisor;
        r.variance = quo[63] ? '1 : quo[VarWidth-1:0];
        r.var_ok   = 1'b1;
      end
      r.mean  = mean_now[SmpW-1:0];
      r.count = n_seen[CntW-1:0];
      stats_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        fails++;
      end
    endfunction

    // Match one result beat against the oldest outstanding prediction
    function void check_result(stats_t got);
      stats_t want;
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual mean %h count %h",
                 $time, got.mean, got.count);
        fails++;
        return;
      end
      want = stats_due.pop_front();
      compare_field("mean", 64'(want.mean), 64'(got.mean));
      compare_field("variance", 64'(want.variance), 64'(got.variance));
      compare_field("variance_valid", 64'(want.var_ok), 64'(got.var_ok));
      compare_field("sample_count", 64'(want.count), 64'(got.count));
    endfunction

    function int pending();
      return stats_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rmv_smp_if smp ();
  rmv_res_if res ();

  running_mean_variance dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .smp_i (smp),
    .res_o (res)
  );

  mean_var_tracker tracker = new();

  int     results_seen = 0;
  int     idle_cycles  = 0;
  bit     tx_calm      = 1'b0;
  bit     rx_calm      = 1'b0;
  bit     hold_done    = 1'b0;
  bit     beat_seen;
  stats_t res_now;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none at all while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 160);
  endfunction

  // Sample close to a center, deviation mostly moderate with rare outliers
  function automatic logic signed [SmpW-1:0] sample_near(longint center);
    int     k;
    longint dev, v;
    k = ($urandom_range(0, 63) == 0) ? $urandom_range(25, 27) : $urandom_range(0, 22);
    dev = $urandom_range(0, (1 << k) - 1);
    v = $urandom_range(0, 1) ? center - dev : center + dev;
    if (v > MaxSample) v = MaxSample;
    if (v < MinSample) v = MinSample;
    return v[SmpW-1:0];
  endfunction

  // Offer one sample beat; enter and leave at a falling edge
  task automatic send_sample(logic signed [SmpW-1:0] x);
    int gap;
    if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= x;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
  endtask

  // Stimulus: small directed values, bounded random, then extremes to saturate the sum
  initial begin
    longint center;
    rst_n      = 1'b0;
    smp.valid  = 1'b0;
    smp.sample = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first sample, zero deviation, truncation toward zero both ways, tiny steps
    send_sample(0);
    send_sample(0);
    send_sample(-7);
    send_sample(5);
    send_sample(1);
    send_sample(-1);
    send_sample(32'sh0001_0000);
    send_sample(-32'sh0001_8000);
    send_sample(32'sh0000_7fff);
    send_sample(3);

    // keep deviations bounded so the squared sum stays clear of saturation
    center = $signed($urandom) >>> 4;
    for (int i = 0; i < RandItems; i++) send_sample(sample_near(center));

    // full-scale swings drive the sum into saturation, then it must stay there
    for (int j = 0; j < 12; j++) send_sample(SmpW'((j % 2 == 0) ? MaxSample : MinSample));
    send_sample(0);
    for (int j = 0; j < 30; j++) send_sample($urandom);
    smp.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off to fill the block
  initial begin
    int g;
    res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        res.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
        g = pick_gap(rx_calm);
        if (g > 0) begin
          res.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  // Monitor both channels at the rising edge; stop if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      beat_seen = 1'b0;
      if (res.valid && res.ready) begin
        res_now.mean     = res.mean;
        res_now.variance = res.variance;
        res_now.var_ok   = res.variance_valid;
        res_now.count    = res.sample_count;
        tracker.check_result(res_now);
        results_seen++;
        beat_seen = 1'b1;
      end
      if (smp.valid && smp.ready) begin
        tracker.note_sample(smp.sample);
        beat_seen = 1'b1;
      end
      idle_cycles = beat_seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
